// ===== hw/rtl/utu8_pkg.sv =====
package utu8_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int CMD_BYTES  = 6;
  localparam int ADDR_W     = 3;

  localparam logic [1:0] NUL_DROP   = 2'd0;
  localparam logic [1:0] NUL_MUTF8  = 2'd1;
  localparam logic [1:0] NUL_SINGLE = 2'd2;

  localparam logic REG_NUL_MODE     = 1'b0;
  localparam logic REG_OUT_CAPACITY = 1'b1;

  localparam logic [20:0] REPL_CHAR    = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] CAPACITY_RST = 16'hFFFF;
  localparam logic [5:0]  HI_SUR_TAG   = 6'b110110;
  localparam logic [5:0]  LO_SUR_TAG   = 6'b110111;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      fin;
    logic [15:0]               base;
  } cmd_t;

  function automatic enc_t encode_cp(logic [20:0] cp, logic [1:0] nul_mode);
    enc_t e;
    e = '0;
    if (cp == '0) begin
      unique case (nul_mode)
        NUL_SINGLE: begin
          e.len = 3'd1;
        end
        NUL_MUTF8: begin
          e.bytes[0] = 8'hC0;
          e.bytes[1] = 8'h80;
          e.len      = 3'd2;
        end
        default: e.len = 3'd0;
      endcase
    end else if (cp <= 21'h00007F) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

// ===== hw/rtl/utu8_unit_if.sv =====
interface utu8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_value;
  logic        is_last;

  modport source (output valid, output unit_value, output is_last, input ready);
  modport sink (input valid, input unit_value, input is_last, output ready);
endinterface

// ===== hw/rtl/utu8_byte_if.sv =====
interface utu8_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [15:0] total_len;
  logic        last;

  modport source (output valid, output out_byte, output byte_valid, output total_len,
                  output last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input total_len,
                input last, output ready);
endinterface

// ===== hw/rtl/utu8_front.sv =====
module utu8_front (
  input  logic            clk,
  input  logic            rst,
  utu8_unit_if.sink       code_units,
  input  logic [1:0]      nul_mode,
  input  logic [15:0]     out_capacity,
  input  logic            full,
  output logic            push,
  output utu8_pkg::cmd_t  cmd
);

  logic [15:0] held_high;
  logic        held_valid;
  logic [15:0] out_count;
  logic [15:0] out_count_next;

  logic [15:0] u;
  logic        is_hi;
  logic        is_lo;
  logic        pair;
  logic        a_need;
  logic        a_ok;
  logic        b_need;
  logic        b_ok;
  logic [20:0] cp_b;
  logic [2:0]  len_b;
  logic [2:0]  len_a_w;
  logic [2:0]  len_b_w;
  logic [16:0] cap17;
  logic [16:0] c1;
  logic        accept;

  utu8_pkg::enc_t enc_a;
  utu8_pkg::enc_t enc_b;

  assign code_units.ready = !full;
  assign accept = code_units.valid && code_units.ready;

  assign u      = code_units.unit_value;
  assign is_hi  = u[15:10] == utu8_pkg::HI_SUR_TAG;
  assign is_lo  = u[15:10] == utu8_pkg::LO_SUR_TAG;
  assign pair   = held_valid && is_lo;
  assign a_need = held_valid && !is_lo;
  assign b_need = !(is_hi && !code_units.is_last);

  always_comb begin
    if (pair) begin
      cp_b = utu8_pkg::SUPP_BASE + {1'b0, held_high[9:0], u[9:0]};
    end else if (is_lo || is_hi) begin
      cp_b = utu8_pkg::REPL_CHAR;
    end else begin
      cp_b = {5'b0, u};
    end
  end

  assign enc_a = utu8_pkg::encode_cp(utu8_pkg::REPL_CHAR, nul_mode);
  assign enc_b = utu8_pkg::encode_cp(cp_b, nul_mode);
  assign len_b = b_need ? enc_b.len : 3'd0;

  assign cap17   = {1'b0, out_capacity};
  assign a_ok    = a_need && ({1'b0, out_count} + 17'd3 <= cap17);
  assign len_a_w = a_ok ? 3'd3 : 3'd0;
  assign c1      = {1'b0, out_count} + {14'b0, len_a_w};
  assign b_ok    = (len_b != 3'd0) && (c1 + {14'b0, len_b} <= cap17);
  assign len_b_w = b_ok ? len_b : 3'd0;

  always_comb begin
    cmd = '0;
    if (a_ok) begin
      cmd.bytes[2:0] = enc_a.bytes[2:0];
      if (b_ok) begin
        cmd.bytes[5:3] = enc_b.bytes[2:0];
      end
    end else if (b_ok) begin
      cmd.bytes[3:0] = enc_b.bytes;
    end
    cmd.count = len_a_w + len_b_w;
    cmd.fin   = code_units.is_last;
    cmd.base  = out_count;
  end

  assign push = accept && ((cmd.count != 3'd0) || code_units.is_last);

  assign out_count_next = code_units.is_last ? 16'd0 : 16'(c1 + {14'b0, len_b_w});

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_count  <= '0;
    end else if (accept) begin
      held_valid <= is_hi && !code_units.is_last;
      out_count  <= out_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_hi && !code_units.is_last) begin
      held_high <= u;
    end
  end

endmodule

// ===== hw/rtl/utu8_fifo.sv =====
module utu8_fifo #(
  parameter int DEPTH = utu8_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utu8_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output utu8_pkg::cmd_t  head,
  output logic            head_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  utu8_pkg::cmd_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = fill == CNT_W'(DEPTH);
  assign head_valid = fill != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/utu8_back.sv =====
module utu8_back (
  input  logic            clk,
  input  logic            rst,
  input  utu8_pkg::cmd_t  head,
  input  logic            head_valid,
  output logic            pop,
  utu8_byte_if.source     utf8_bytes
);

  logic        valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [15:0] total_len;
  logic        last;
  logic [2:0]  idx;

  logic        out_load;
  logic        at_end;
  logic        has_bytes;
  logic        step;
  logic        emit;

  assign utf8_bytes.valid      = valid;
  assign utf8_bytes.out_byte   = out_byte;
  assign utf8_bytes.byte_valid = byte_valid;
  assign utf8_bytes.total_len  = total_len;
  assign utf8_bytes.last       = last;

  assign out_load  = !valid || utf8_bytes.ready;
  assign has_bytes = head.count != 3'd0;
  assign at_end    = idx == head.count - 3'd1;
  assign step      = head_valid && out_load;
  assign emit      = step && (has_bytes || head.fin);
  assign pop       = step && (!has_bytes || at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (out_load) begin
        valid <= emit;
      end
      if (step && has_bytes) begin
        idx <= at_end ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= has_bytes ? head.bytes[idx] : 8'h00;
      byte_valid <= has_bytes;
      total_len  <= has_bytes ? head.base + {13'b0, idx} + 16'd1 : head.base;
      last       <= head.fin && (!has_bytes || at_end);
    end
  end

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder_top.sv =====
// the bytes of an accepted word are queued as a command, then presented from the output register
// throughput: one byte per cycle from the output register while the receiver is ready; a word
//   produces 0 to 6 bytes, usually 1 to 3, sent by the byte serializer
// reset (rst, synchronous): clears the held surrogate, byte count, queue and output valid;
//   nul_mode returns to 0 and out_capacity to 65535
module utf16_to_utf8_encoder_top #(
  parameter int FIFO_DEPTH = utu8_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [utu8_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  utu8_unit_if.sink                   code_units,
  utu8_byte_if.source                 utf8_bytes
);

  logic [1:0]     nul_mode;
  logic [15:0]    out_capacity;
  logic           cfg_wr;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  utu8_pkg::cmd_t cmd;
  utu8_pkg::cmd_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      nul_mode     <= utu8_pkg::NUL_DROP;
      out_capacity <= utu8_pkg::CAPACITY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        utu8_pkg::REG_NUL_MODE:     nul_mode     <= pwdata[1:0];
        utu8_pkg::REG_OUT_CAPACITY: out_capacity <= pwdata[15:0];
        default:                    nul_mode     <= nul_mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      utu8_pkg::REG_NUL_MODE:     prdata = {30'b0, nul_mode};
      utu8_pkg::REG_OUT_CAPACITY: prdata = {16'b0, out_capacity};
      default:                    prdata = '0;
    endcase
  end

  utu8_front u_front (
    .clk          (clk),
    .rst          (rst),
    .code_units   (code_units),
    .nul_mode     (nul_mode),
    .out_capacity (out_capacity),
    .full         (full),
    .push         (push),
    .cmd          (cmd)
  );

  utu8_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  utu8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .utf8_bytes (utf8_bytes)
  );

endmodule

// ===== hw/rtl/utu8_checker.sv =====
module utu8_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic [15:0] total_len,
  input logic        last
);

  // a stalled word holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(total_len) && $stable(last))
    else $error("stalled output word changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && out_byte == 8'h00)
    else $error("end marker not last or not zero");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> total_len != 16'd0)
    else $error("byte carries zero length");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf16_to_utf8_encoder_top utu8_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (utf8_bytes.valid),
  .out_ready  (utf8_bytes.ready),
  .out_byte   (utf8_bytes.out_byte),
  .byte_valid (utf8_bytes.byte_valid),
  .total_len  (utf8_bytes.total_len),
  .last       (utf8_bytes.last)
);
